### rtl/scss_pkg.sv
`timescale 1ns / 1ps
package scss_pkg;

  localparam int LINE_MAX = 4096;
  localparam int COL_W = 13;
  localparam int START_W = 12;

  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_COMMENT = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_SQ1 = 3'd1;
  localparam logic [2:0] MODE_DQ1 = 3'd2;
  localparam logic [2:0] MODE_SQ3 = 3'd3;
  localparam logic [2:0] MODE_DQ3 = 3'd4;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_Q1 = 2'd1;
  localparam logic [1:0] PH_Q2 = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW = 2;

  typedef struct packed {
    logic [7:0] ch;
    logic first_of_line;
    logic last_of_line;
    logic empty_line;
    logic [2:0] start_mode;
  } in_item_t;

  typedef struct packed {
    logic [START_W-1:0] span_start;
    logic [COL_W-1:0] span_limit;
    logic [1:0] kind;
    logic [2:0] next_mode;
    logic last;
  } out_item_t;

  // up to three results produced for one item
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t r0;
    out_item_t r1;
    out_item_t r2;
  } res_group_t;

  function automatic logic is_prefix_letter(input logic [7:0] x);
    logic [7:0] l;
    l = x | 8'h20;
    return ((x >= 8'h41 && x <= 8'h5a) || (x >= 8'h61 && x <= 8'h7a)) &&
           (l == 8'h72 || l == 8'h62 || l == 8'h75 || l == 8'h66);
  endfunction

  function automatic out_item_t mk_res(input logic [11:0] s, input logic [12:0] e,
                                       input logic [1:0] k, input logic [2:0] m);
    out_item_t r;
    r.span_start = s;
    r.span_limit = e;
    r.kind = k;
    r.next_mode = m;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

### rtl/scss_front.sv
`timescale 1ns / 1ps
module scss_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_vld,
  input  scss_pkg::in_item_t    item,
  output scss_pkg::res_group_t  grp,
  output logic                  grp_vld
);

  logic [2:0] mode_r, mode_nxt;
  logic [12:0] col_r, col_nxt;
  logic [11:0] oss_r, oss_nxt;
  logic esc_r, esc_nxt;
  logic cmt_r, cmt_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [1:0] pre_r, pre_nxt;
  logic [1:0] qr_r, qr_nxt;
  logic open_r, open_nxt;
  logic pv_r, pv_nxt;
  logic [11:0] ps_r, ps_nxt;
  logic [12:0] pe_r, pe_nxt;

  scss_pkg::out_item_t res [3];
  logic [1:0] n;

  always_comb begin
    logic [2:0] sm;
    logic [7:0] x;
    logic [7:0] q;
    logic [11:0] c;
    logic body;
    logic [2:0] lm;
    mode_nxt = mode_r; col_nxt = col_r; oss_nxt = oss_r; esc_nxt = esc_r;
    cmt_nxt = cmt_r; ph_nxt = ph_r; pre_nxt = pre_r; qr_nxt = qr_r;
    open_nxt = open_r; pv_nxt = pv_r; ps_nxt = ps_r; pe_nxt = pe_r;
    n = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    x = item.ch;
    sm = (item.start_mode > 3'd4) ? scss_pkg::MODE_NONE : item.start_mode;
    c = col_r[11:0];
    body = 1'b0;
    lm = scss_pkg::MODE_NONE;
    q = 8'h0;
    if (item.empty_line) begin
      col_nxt = '0; oss_nxt = '0; cmt_nxt = 1'b0; ph_nxt = scss_pkg::PH_SCAN;
      mode_nxt = '0; pre_nxt = '0; qr_nxt = '0; esc_nxt = 1'b0;
      open_nxt = 1'b0; pv_nxt = 1'b0; ps_nxt = '0; pe_nxt = '0;
      res[0] = scss_pkg::mk_res('0, '0, scss_pkg::KIND_STATUS, sm);
      n = 2'd1;
    end else begin
      if (item.first_of_line || !open_r) begin
        col_nxt = '0; pv_nxt = 1'b0; cmt_nxt = 1'b0; oss_nxt = '0; open_nxt = 1'b1;
        pre_nxt = '0; qr_nxt = '0; esc_nxt = 1'b0;
        if (sm != scss_pkg::MODE_NONE) begin
          ph_nxt = scss_pkg::PH_BODY; mode_nxt = sm;
        end else begin
          ph_nxt = scss_pkg::PH_SCAN; mode_nxt = '0;
        end
      end else if (pv_r) begin
        res[0] = scss_pkg::mk_res(ps_r, pe_r, scss_pkg::KIND_STRING, '0);
        n = 2'd1;
        pv_nxt = 1'b0;
      end
      c = col_nxt[11:0];
      if (col_nxt < 13'(scss_pkg::LINE_MAX)) begin
        q = (mode_nxt == scss_pkg::MODE_SQ1 || mode_nxt == scss_pkg::MODE_SQ3) ?
            scss_pkg::CH_SQUOTE : scss_pkg::CH_DQUOTE;
        body = 1'b1;
        if (ph_nxt == scss_pkg::PH_Q2) begin
          if (x == q) begin
            ph_nxt = scss_pkg::PH_BODY; mode_nxt = mode_nxt + 3'd2; qr_nxt = '0;
            body = 1'b0;
          end else begin
            res[n] = scss_pkg::mk_res(oss_nxt, {1'b0, c}, scss_pkg::KIND_STRING, '0);
            n = n + 2'd1;
            ph_nxt = scss_pkg::PH_SCAN; mode_nxt = '0; pre_nxt = '0; qr_nxt = '0;
            esc_nxt = 1'b0;
          end
        end else if (ph_nxt == scss_pkg::PH_Q1) begin
          if (x == q) begin
            ph_nxt = scss_pkg::PH_Q2; body = 1'b0;
          end else begin
            ph_nxt = scss_pkg::PH_BODY; esc_nxt = 1'b0;
          end
        end
        if (body && ph_nxt == scss_pkg::PH_BODY) begin
          if (mode_nxt >= 3'd3) begin
            if (x == q) begin
              if (qr_nxt >= 2'd2) begin
                pv_nxt = 1'b1; ps_nxt = oss_nxt; pe_nxt = {1'b0, c} + 13'd1;
                ph_nxt = scss_pkg::PH_SCAN; mode_nxt = '0; pre_nxt = '0; qr_nxt = '0;
                esc_nxt = 1'b0;
              end else begin
                qr_nxt = qr_nxt + 2'd1;
              end
            end else begin
              qr_nxt = '0;
            end
          end else if (esc_nxt) begin
            esc_nxt = 1'b0;
          end else if (x == scss_pkg::CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (x == q) begin
            pv_nxt = 1'b1; ps_nxt = oss_nxt; pe_nxt = {1'b0, c} + 13'd1;
            ph_nxt = scss_pkg::PH_SCAN; mode_nxt = '0; pre_nxt = '0; qr_nxt = '0;
            esc_nxt = 1'b0;
          end
        end else if (body && !cmt_nxt) begin
          if (x == scss_pkg::CH_HASH) begin
            cmt_nxt = 1'b1; oss_nxt = c;
          end else if (x == scss_pkg::CH_SQUOTE || x == scss_pkg::CH_DQUOTE) begin
            oss_nxt = c - {10'd0, pre_nxt};
            mode_nxt = (x == scss_pkg::CH_SQUOTE) ? scss_pkg::MODE_SQ1 : scss_pkg::MODE_DQ1;
            ph_nxt = scss_pkg::PH_Q1; pre_nxt = '0;
          end else if (scss_pkg::is_prefix_letter(x)) begin
            if (pre_nxt < 2'd2) pre_nxt = pre_nxt + 2'd1;
          end else begin
            pre_nxt = '0;
          end
        end
        col_nxt = col_nxt + 13'd1;
      end
      if (item.last_of_line) begin
        if (pv_nxt) begin
          res[n] = scss_pkg::mk_res(ps_nxt, pe_nxt, scss_pkg::KIND_STRING, '0);
          n = n + 2'd1;
          pv_nxt = 1'b0;
        end
        if (cmt_nxt) begin
          res[n] = scss_pkg::mk_res(oss_nxt, col_nxt, scss_pkg::KIND_COMMENT, '0);
          n = n + 2'd1;
        end else if (ph_nxt == scss_pkg::PH_Q1 || ph_nxt == scss_pkg::PH_Q2) begin
          res[n] = scss_pkg::mk_res(oss_nxt, col_nxt, scss_pkg::KIND_STRING, '0);
          n = n + 2'd1;
          if (ph_nxt == scss_pkg::PH_Q1) lm = mode_nxt;
        end else if (ph_nxt == scss_pkg::PH_BODY) begin
          if (col_nxt > {1'b0, oss_nxt}) begin
            res[n] = scss_pkg::mk_res(oss_nxt, col_nxt, scss_pkg::KIND_STRING, '0);
            n = n + 2'd1;
          end
          lm = mode_nxt;
        end
        res[n] = scss_pkg::mk_res('0, '0, scss_pkg::KIND_STATUS, lm);
        n = n + 2'd1;
        cmt_nxt = 1'b0; ph_nxt = scss_pkg::PH_SCAN; mode_nxt = '0; pre_nxt = '0;
        qr_nxt = '0; esc_nxt = 1'b0; open_nxt = 1'b0;
      end
    end
    grp.cnt = n;
    grp.r0 = res[0];
    grp.r1 = res[1];
    grp.r2 = res[2];
    if (n == 2'd1) grp.r0.last = 1'b1;
    if (n == 2'd2) grp.r1.last = 1'b1;
    if (n == 2'd3) grp.r2.last = 1'b1;
    grp_vld = item_vld && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; col_r <= '0; oss_r <= '0; esc_r <= 1'b0; cmt_r <= 1'b0;
      ph_r <= scss_pkg::PH_SCAN; pre_r <= '0; qr_r <= '0; open_r <= 1'b0;
      pv_r <= 1'b0; ps_r <= '0; pe_r <= '0;
    end else if (item_vld) begin
      mode_r <= mode_nxt; col_r <= col_nxt; oss_r <= oss_nxt; esc_r <= esc_nxt;
      cmt_r <= cmt_nxt; ph_r <= ph_nxt; pre_r <= pre_nxt; qr_r <= qr_nxt;
      open_r <= open_nxt; pv_r <= pv_nxt; ps_r <= ps_nxt; pe_r <= pe_nxt;
    end
  end

endmodule

### rtl/scss_back.sv
`timescale 1ns / 1ps
module scss_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  grp_vld,
  input  scss_pkg::res_group_t  grp,
  output logic                  grp_full,
  output scss_pkg::out_item_t   out_item,
  output logic                  out_empty,
  input  logic                  out_pop
);

  scss_pkg::res_group_t q_r [scss_pkg::RQ_DEPTH];
  logic [scss_pkg::RQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [scss_pkg::RQ_AW:0] cnt_r, cnt_nxt;
  logic [1:0] sub_r, sub_nxt;
  scss_pkg::res_group_t head;
  logic done;

  assign head = q_r[rp_r];
  assign out_empty = (cnt_r == '0);
  assign grp_full = (cnt_r == (scss_pkg::RQ_AW + 1)'(scss_pkg::RQ_DEPTH));

  always_comb begin
    case (sub_r)
      2'd0: out_item = head.r0;
      2'd1: out_item = head.r1;
      default: out_item = head.r2;
    endcase
  end

  always_comb begin
    done = out_pop && !out_empty && (sub_r + 2'd1 == head.cnt);
    sub_nxt = sub_r;
    if (out_pop && !out_empty) sub_nxt = done ? 2'd0 : sub_r + 2'd1;
    rp_nxt = done ? rp_r + 1'b1 : rp_r;
    wp_nxt = grp_vld ? wp_r + 1'b1 : wp_r;
    cnt_nxt = cnt_r + {{scss_pkg::RQ_AW{1'b0}}, grp_vld}
                    - {{scss_pkg::RQ_AW{1'b0}}, done};
  end

  always_ff @(posedge clk) begin
    if (grp_vld) q_r[wp_r] <= grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt; sub_r <= sub_nxt;
    end
  end

endmodule

### rtl/string_comment_span_scanner_unit.sv
`timescale 1ns / 1ps
// Scans Python-style source one byte per transfer and reports string and comment
// spans plus a status result at every line end. It accepts one item per cycle
// while in_full is low; the results of an item (zero to three) enter a queue
// the cycle after its transfer and leave it one per cycle while out_pop is high;
// the queue holds the result groups of up to four items, so the sustained rate
// is set by the output side and in_full rises once four groups are waiting.
module string_comment_span_scanner_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  scss_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output scss_pkg::out_item_t out_item
);

  scss_pkg::res_group_t grp;
  logic grp_vld;

  scss_front u_front (
    .clk(clk), .rst_n(rst_n), .item_vld(in_push && !in_full), .item(in_item),
    .grp(grp), .grp_vld(grp_vld)
  );

  scss_back u_back (
    .clk(clk), .rst_n(rst_n), .grp_vld(grp_vld), .grp(grp), .grp_full(in_full),
    .out_item(out_item), .out_empty(out_empty), .out_pop(out_pop)
  );

endmodule

### rtl/scss_checker.sv
`timescale 1ns / 1ps
module scss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input scss_pkg::out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while waiting");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind == scss_pkg::KIND_STATUS |-> out_item.last)
    else $error("status result not last");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.kind != 2'd3)
    else $error("bad kind");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind != scss_pkg::KIND_STATUS |->
      out_item.next_mode == scss_pkg::MODE_NONE)
    else $error("span carries mode");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && in_full && !out_pop |=> in_full)
    else $error("full dropped without a result transfer");

endmodule

bind string_comment_span_scanner_unit scss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
);

### tb/string_comment_span_scanner_unit_checker.sv
`timescale 1ns / 1ps
module string_comment_span_scanner_unit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  scss_pkg::in_item_t  in_item,
  input  logic                out_empty,
  input  logic                out_pop,
  input  scss_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count
);

  scss_pkg::out_item_t span_q[$];

  logic [2:0]  mode_r;
  logic [12:0] col_r;
  logic [11:0] open_start_r;
  logic        esc_r;
  logic        comment_r;
  logic [1:0]  phase_r;
  logic [1:0]  prefix_r;
  logic [1:0]  qrun_r;
  logic        line_open_r;
  logic        pend_v_r;
  logic [11:0] pend_s_r;
  logic [12:0] pend_e_r;
  scss_pkg::out_item_t step_res[$];

  function automatic logic [7:0] quote_for_mode(input logic [2:0] m);
    return (m == scss_pkg::MODE_SQ1 || m == scss_pkg::MODE_SQ3) ?
           scss_pkg::CH_SQUOTE : scss_pkg::CH_DQUOTE;
  endfunction

  function automatic logic letter_ok(input logic [7:0] x);
    logic [7:0] l;
    l = x | 8'h20;
    return ((x >= 8'h41 && x <= 8'h5a) || (x >= 8'h61 && x <= 8'h7a)) &&
           (l == "r" || l == "b" || l == "u" || l == "f");
  endfunction

  function automatic scss_pkg::out_item_t span_res(input logic [11:0] s,
                                                   input logic [12:0] e,
                                                   input logic [1:0] k,
                                                   input logic [2:0] m);
    scss_pkg::out_item_t r;
    r.span_start = s;
    r.span_limit = e;
    r.kind = k;
    r.next_mode = m;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic add_res(input scss_pkg::out_item_t r);
    step_res = {step_res, r};
  endtask

  task automatic leave_string();
    phase_r = scss_pkg::PH_SCAN;
    mode_r = scss_pkg::MODE_NONE;
    prefix_r = 2'd0;
    qrun_r = 2'd0;
    esc_r = 1'b0;
  endtask

  task automatic clear_all();
    col_r = 13'd0;
    open_start_r = 12'd0;
    comment_r = 1'b0;
    leave_string();
    line_open_r = 1'b0;
    pend_v_r = 1'b0;
    pend_s_r = 12'd0;
    pend_e_r = 13'd0;
  endtask

  task automatic scan_byte(input logic [7:0] x, input logic [12:0] c);
    logic [7:0] q;
    q = quote_for_mode(mode_r);
    if (phase_r == scss_pkg::PH_Q2) begin
      if (x == q) begin
        phase_r = scss_pkg::PH_BODY;
        mode_r = mode_r + 3'd2;
        qrun_r = 2'd0;
        return;
      end
      add_res(span_res(open_start_r, c, scss_pkg::KIND_STRING, scss_pkg::MODE_NONE));
      leave_string();
    end else if (phase_r == scss_pkg::PH_Q1) begin
      if (x == q) begin
        phase_r = scss_pkg::PH_Q2;
        return;
      end
      phase_r = scss_pkg::PH_BODY;
      esc_r = 1'b0;
    end
    if (phase_r == scss_pkg::PH_BODY) begin
      if (mode_r >= scss_pkg::MODE_SQ3) begin
        if (x == q) begin
          qrun_r = qrun_r + 2'd1;
          if (qrun_r >= 2'd3) begin
            pend_v_r = 1'b1;
            pend_s_r = open_start_r;
            pend_e_r = c + 13'd1;
            leave_string();
          end
        end else begin
          qrun_r = 2'd0;
        end
      end else if (esc_r) begin
        esc_r = 1'b0;
      end else if (x == scss_pkg::CH_BSLASH) begin
        esc_r = 1'b1;
      end else if (x == q) begin
        pend_v_r = 1'b1;
        pend_s_r = open_start_r;
        pend_e_r = c + 13'd1;
        leave_string();
      end
      return;
    end
    if (comment_r) return;
    if (x == scss_pkg::CH_HASH) begin
      comment_r = 1'b1;
      open_start_r = c[11:0];
    end else if (x == scss_pkg::CH_SQUOTE || x == scss_pkg::CH_DQUOTE) begin
      open_start_r = c[11:0] - {10'd0, prefix_r};
      mode_r = (x == scss_pkg::CH_SQUOTE) ? scss_pkg::MODE_SQ1 : scss_pkg::MODE_DQ1;
      phase_r = scss_pkg::PH_Q1;
      prefix_r = 2'd0;
    end else if (letter_ok(x)) begin
      if (prefix_r < 2'd2) prefix_r = prefix_r + 2'd1;
    end else begin
      prefix_r = 2'd0;
    end
  endtask

  task automatic predict_spans(input scss_pkg::in_item_t it);
    logic [2:0]  sm;
    logic [2:0]  nm;
    logic [12:0] len;
    step_res.delete();
    sm = (it.start_mode > scss_pkg::MODE_DQ3) ? scss_pkg::MODE_NONE : it.start_mode;
    if (it.empty_line) begin
      clear_all();
      add_res(span_res(12'd0, 13'd0, scss_pkg::KIND_STATUS, sm));
    end else begin
      if (it.first_of_line || !line_open_r) begin
        col_r = 13'd0;
        pend_v_r = 1'b0;
        comment_r = 1'b0;
        leave_string();
        open_start_r = 12'd0;
        line_open_r = 1'b1;
        if (sm != scss_pkg::MODE_NONE) begin
          phase_r = scss_pkg::PH_BODY;
          mode_r = sm;
        end
      end else if (pend_v_r) begin
        add_res(span_res(pend_s_r, pend_e_r, scss_pkg::KIND_STRING, scss_pkg::MODE_NONE));
        pend_v_r = 1'b0;
      end
      if (col_r < scss_pkg::LINE_MAX) begin
        scan_byte(it.ch, col_r);
        col_r = col_r + 13'd1;
      end
      if (it.last_of_line) begin
        nm = scss_pkg::MODE_NONE;
        len = col_r;
        if (pend_v_r) begin
          add_res(span_res(pend_s_r, pend_e_r, scss_pkg::KIND_STRING, scss_pkg::MODE_NONE));
          pend_v_r = 1'b0;
        end
        if (comment_r) begin
          add_res(span_res(open_start_r, len, scss_pkg::KIND_COMMENT, scss_pkg::MODE_NONE));
        end else if (phase_r == scss_pkg::PH_Q1) begin
          add_res(span_res(open_start_r, len, scss_pkg::KIND_STRING, scss_pkg::MODE_NONE));
          nm = mode_r;
        end else if (phase_r == scss_pkg::PH_Q2) begin
          add_res(span_res(open_start_r, len, scss_pkg::KIND_STRING, scss_pkg::MODE_NONE));
        end else if (phase_r == scss_pkg::PH_BODY) begin
          if (len > {1'b0, open_start_r})
            add_res(span_res(open_start_r, len, scss_pkg::KIND_STRING,
                             scss_pkg::MODE_NONE));
          nm = mode_r;
        end
        add_res(span_res(12'd0, 13'd0, scss_pkg::KIND_STATUS, nm));
        comment_r = 1'b0;
        leave_string();
        line_open_r = 1'b0;
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) span_q = {span_q, step_res[i]};
  endtask

  always @(posedge clk) begin
    scss_pkg::out_item_t exp_r;
    if (!rst_n) begin
      clear_all();
      span_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (span_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected transfer %p", out_item);
        end else begin
          exp_r = span_q.pop_front();
          if (out_item !== exp_r) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch exp %p got %p", exp_r, out_item);
          end
        end
      end
      if (in_push && !in_full) predict_spans(in_item);
      pending_count <= span_q.size();
    end
  end

endmodule

### tb/string_comment_span_scanner_unit_test.sv
`timescale 1ns / 1ps
module string_comment_span_scanner_unit_test;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_push = 0;
  logic                in_full;
  scss_pkg::in_item_t  in_item = '0;
  logic                out_empty;
  logic                out_pop = 0;
  scss_pkg::out_item_t out_item;
  int                  fail_count;
  int                  pending_count;
  logic                hold_off = 0;
  logic                stim_done = 0;

  string_comment_span_scanner_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  string_comment_span_scanner_unit_checker i_chk (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0, 1: return scss_pkg::CH_SQUOTE;
      2, 3: return scss_pkg::CH_DQUOTE;
      4: return scss_pkg::CH_HASH;
      5: return scss_pkg::CH_BSLASH;
      6: return "r";
      7: return "B";
      8: return "f";
      9: return "U";
      10: return "a";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic [7:0] c, input logic f, input logic l,
                           input logic e, input logic [2:0] m);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(posedge clk);
    end
    in_item <= '{ch: c, first_of_line: f, last_of_line: l, empty_line: e, start_mode: m};
    in_push <= 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_line(input string s, input logic [2:0] m);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], i == 0, i == s.len() - 1, 1'b0, m);
  endtask

  task automatic send_random_line(input int n);
    logic [2:0] m;
    m = 3'($urandom_range(0, 7));
    for (int i = 0; i < n; i++)
      send_item(pick_char(), i == 0, i == n - 1, 1'b0, m);
  endtask

  initial begin
    int sent;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_line("rb'a\\'b'#x", scss_pkg::MODE_NONE);
    send_line("''x\"\"\"q\"\"\"", scss_pkg::MODE_NONE);
    send_line("ab'''", scss_pkg::MODE_SQ3);
    send_line("x\\", scss_pkg::MODE_DQ1);
    send_item(8'hff, 1'b1, 1'b0, 1'b0, 3'd7);
    send_item(8'h00, 1'b0, 1'b0, 1'b0, 3'd5);
    send_item("\"", 1'b1, 1'b1, 1'b0, scss_pkg::MODE_NONE);
    send_item(8'h00, 1'b0, 1'b0, 1'b1, scss_pkg::MODE_DQ3);
    send_item("'", 1'b0, 1'b0, 1'b0, scss_pkg::MODE_NONE);
    send_item("'", 1'b0, 1'b1, 1'b0, scss_pkg::MODE_NONE);
    in_push <= 0;
    sent = 33;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    hold_off <= 1;
    for (int i = 0; i < 12; i++)
      send_item("#", i == 0, 1'b1, 1'b0, scss_pkg::MODE_NONE);
    hold_off <= 0;
    sent += 12;
    while (sent < 310) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 14);
      if ($urandom_range(0, 19) == 0) begin
        send_item(pick_char(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        n = 1;
      end else begin
        send_random_line(n);
      end
      sent += n;
    end
    in_push <= 0;
    stim_done <= 1;
  end

  initial begin
    int g;
    int k;
    logic held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1;
        out_pop <= 0;
        k = 0;
        while (k < 40) begin
          @(posedge clk);
          k++;
        end
        out_pop <= 1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_pop <= 0;
          repeat (g) @(posedge clk);
        end
        out_pop <= 1;
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("string_comment_span_scanner_unit verification clean");
    else
      $display("string_comment_span_scanner_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("string_comment_span_scanner_unit verification failed");
    $finish;
  end
endmodule
